FILE: design/sbpl_pkg.sv
// Shared types and constants of the serial boot packet loader.
package sbpl_pkg;

  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int MAX_CHUNK = 8;
  localparam int BUF_LEN   = (MAX_CHUNK > 8) ? MAX_CHUNK + 1 : 9;
  localparam int BUF_AW    = $clog2(BUF_LEN);

  localparam logic [7:0] CMD_PING     = 8'h20;
  localparam logic [7:0] CMD_DOWNLOAD = 8'h21;
  localparam logic [7:0] CMD_RUN      = 8'h22;
  localparam logic [7:0] CMD_STATUS   = 8'h23;
  localparam logic [7:0] CMD_SEND     = 8'h24;
  localparam logic [7:0] CMD_RESET    = 8'h25;

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_UNKNOWN = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_ADDR    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_SIZE = 2'd0,
    PH_SUM  = 2'd1,
    PH_DATA = 2'd2,
    PH_TERM = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WRITE,
    S_CLEAR,
    S_RESULT
  } eng_state_t;

  typedef logic [BUF_LEN-1:0][7:0] pbuf_t;

  // Packet view from the parser; done marks a terminator beat.
  typedef struct packed {
    logic       done;
    logic       bad;
    logic [7:0] size;
    pbuf_t      buffer;
  } pkt_t;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] command;
    status_t    status;
    logic [7:0] read_data;
  } res_t;

endpackage

FILE: design/sbpl_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module sbpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/sbpl_parser.sv
// Packet framing: size, checksum, payload buffer and terminator tracking.
module sbpl_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          byte_fire,
  input  logic [7:0]    rx_byte,
  output sbpl_pkg::pkt_t pkt
);
  import sbpl_pkg::*;

  phase_t     phase;
  logic [7:0] size;
  logic [7:0] exp_sum;
  logic [7:0] run_sum;
  logic [7:0] count;
  pbuf_t      buffer;
  logic [7:0] plen;
  logic [8:0] count_inc;

  assign plen      = (size >= 8'd2) ? size - 8'd2 : 8'd0;
  assign count_inc = {1'b0, count} + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_SIZE;
      size    <= '0;
      exp_sum <= '0;
      run_sum <= '0;
      count   <= '0;
      buffer  <= '0;
    end else if (byte_fire) begin
      unique case (phase)
        PH_SIZE: begin
          size    <= rx_byte;
          run_sum <= '0;
          count   <= '0;
          buffer  <= '0;
          phase   <= PH_SUM;
        end
        PH_SUM: begin
          exp_sum <= rx_byte;
          phase   <= (plen != 8'd0) ? PH_DATA : PH_TERM;
        end
        PH_DATA: begin
          if (count < 8'(BUF_LEN)) begin
            buffer[count[BUF_AW-1:0]] <= rx_byte;
          end
          run_sum <= run_sum + rx_byte;
          count   <= count_inc[7:0];
          if (count_inc >= {1'b0, plen}) begin
            phase <= PH_TERM;
          end
        end
        PH_TERM: begin
          phase <= PH_SIZE;
        end
        default: phase <= PH_SIZE;
      endcase
    end
  end

  assign pkt.done   = (phase == PH_TERM);
  assign pkt.bad    = (rx_byte != 8'd0) || (exp_sum != run_sum);
  assign pkt.size   = size;
  assign pkt.buffer = buffer;

endmodule

FILE: design/sbpl_engine.sv
// Command execution, pointers, sticky status and image memory sequencing.
module sbpl_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_fire,
  input  logic                         in_op,
  input  logic [sbpl_pkg::MEM_AW-1:0]  in_addr,
  input  sbpl_pkg::pkt_t               pkt,
  input  logic                         res_free,
  output logic                         in_ready,
  output sbpl_pkg::res_t               res
);
  import sbpl_pkg::*;

  eng_state_t        state, state_next;
  status_t           error_status, error_status_next;
  logic [31:0]       wptr, wptr_next;
  logic [31:0]       remain, remain_next;
  logic              res_kind, res_kind_next;
  logic [7:0]        res_cmd, res_cmd_next;
  logic [BUF_AW-1:0] idx, idx_next;
  logic [BUF_AW-1:0] chunk_n, chunk_n_next;
  logic [MEM_AW-1:0] clr, clr_next;

  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [7:0]        ram_rdata;

  logic [7:0]        cmd;
  logic [7:0]        n;
  logic [32:0]       end_addr;

  assign cmd      = pkt.buffer[0];
  assign n        = pkt.size - 8'd3;
  assign end_addr = {1'b0, wptr} + {25'd0, n};

  sbpl_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_image (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      error_status <= STAT_OK;
      wptr         <= '0;
      remain       <= '0;
      res_kind     <= KIND_PACKET;
      res_cmd      <= '0;
      idx          <= '0;
      chunk_n      <= '0;
      clr          <= '0;
    end else begin
      state        <= state_next;
      error_status <= error_status_next;
      wptr         <= wptr_next;
      remain       <= remain_next;
      res_kind     <= res_kind_next;
      res_cmd      <= res_cmd_next;
      idx          <= idx_next;
      chunk_n      <= chunk_n_next;
      clr          <= clr_next;
    end
  end

  always_comb begin
    state_next        = state;
    error_status_next = error_status;
    wptr_next         = wptr;
    remain_next       = remain;
    res_kind_next     = res_kind;
    res_cmd_next      = res_cmd;
    idx_next          = idx;
    chunk_n_next      = chunk_n;
    clr_next          = clr;
    ram_we            = 1'b0;
    ram_waddr         = wptr[MEM_AW-1:0];
    ram_wdata         = pkt.buffer[idx];
    ram_re            = 1'b0;
    in_ready          = 1'b0;
    res.valid         = 1'b0;
    res.kind          = res_kind;
    res.command       = res_cmd;
    res.status        = error_status;
    res.read_data     = (res_kind == KIND_READ) ? ram_rdata : 8'd0;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_op == OP_READ) begin
          ram_re        = 1'b1;
          res_kind_next = KIND_READ;
          res_cmd_next  = 8'd0;
          state_next    = S_READ;
        end else if (in_fire && pkt.done) begin
          res_kind_next = KIND_PACKET;
          state_next    = S_RESULT;
          if (pkt.bad) begin
            error_status_next = STAT_INVALID;
          end
          if (pkt.size < 8'd3) begin
            error_status_next = STAT_INVALID;
            res_cmd_next      = 8'd0;
          end else begin
            res_cmd_next = cmd;
            unique case (cmd)
              CMD_PING, CMD_RUN, CMD_STATUS: ;
              CMD_DOWNLOAD: begin
                wptr_next   = {pkt.buffer[1], pkt.buffer[2], pkt.buffer[3], pkt.buffer[4]};
                remain_next = {pkt.buffer[5], pkt.buffer[6], pkt.buffer[7], pkt.buffer[8]};
              end
              CMD_SEND: begin
                priority if (n > 8'(MAX_CHUNK)) begin
                  error_status_next = STAT_INVALID;
                end else if (end_addr > 33'(MEM_BYTES)) begin
                  error_status_next = STAT_ADDR;
                end else if (remain < {24'd0, n}) begin
                  error_status_next = STAT_INVALID;
                end else if (n != 8'd0) begin
                  idx_next     = BUF_AW'(1);
                  chunk_n_next = n[BUF_AW-1:0];
                  state_next   = S_WRITE;
                end
              end
              CMD_RESET: begin
                clr_next   = '0;
                state_next = S_CLEAR;
              end
              default: error_status_next = STAT_UNKNOWN;
            endcase
          end
        end
      end
      S_READ: begin
        state_next = S_RESULT;
      end
      S_WRITE: begin
        ram_we      = 1'b1;
        wptr_next   = wptr + 32'd1;
        remain_next = remain - 32'd1;
        idx_next    = idx + BUF_AW'(1);
        if (idx == chunk_n) begin
          state_next = S_RESULT;
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr;
        ram_wdata = 8'd0;
        clr_next  = clr + MEM_AW'(1);
        if (clr == MEM_AW'(MEM_BYTES - 1)) begin
          wptr_next   = '0;
          remain_next = '0;
          state_next  = S_RESULT;
        end
      end
      S_RESULT: begin
        res.valid = 1'b1;
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> wptr < 32'(MEM_BYTES))
    else $error("chunk write outside image memory");

  a_write_counts: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |=> remain == $past(remain) - 32'd1 && wptr == $past(wptr) + 32'd1)
    else $error("pointer and remaining count out of step");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_RESULT && !res_free |=> state == S_RESULT && $stable(res_cmd))
    else $error("pending result lost");

  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR && clr == MEM_AW'(MEM_BYTES - 1) |=> wptr == 32'd0 && remain == 32'd0)
    else $error("pointers not cleared after memory clear");

endmodule

FILE: design/serial_boot_packet_loader.sv
// Top level of the serial boot packet loader: stream ports and result register.
//
//  channel  dir  beat contents
//  s_axis   in   tuser = op; tdata = rx_byte[7:0], read_addr[19:8], zero[23:20]
//  m_axis   out  tuser = kind; tdata = command[7:0], status[9:8], read_data[17:10]
//
// A serial byte that does not end a packet leaves the engine idle and ready.
// A read passes through the read and result states; a finished packet reaches
// the result state via the write state for each byte of a send-data chunk or a
// reset's clear of all image memory, all through the single write port of it.
// rst clears all control state; image memory contents stay undefined until written.
// A result waits in the output register while m_axis_tready is low; input is
// taken again once the result is in that register.
module serial_boot_packet_loader (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // rx_byte[7:0], read_addr[19:8]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // command[7:0], status[9:8], read_data[17:10]
  output logic        m_axis_tuser    // kind
);
  import sbpl_pkg::*;

  logic       in_fire;
  logic       res_free;
  pkt_t       pkt;
  res_t       res;
  logic       out_kind;
  logic [7:0] out_cmd;
  status_t    out_status;
  logic [7:0] out_rdata;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign res_free = !m_axis_tvalid || m_axis_tready;

  sbpl_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_fire (in_fire && s_axis_tuser == OP_RX),
    .rx_byte   (s_axis_tdata[7:0]),
    .pkt       (pkt)
  );

  sbpl_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_op    (s_axis_tuser),
    .in_addr  (s_axis_tdata[8 +: MEM_AW]),
    .pkt      (pkt),
    .res_free (res_free),
    .in_ready (s_axis_tready),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.valid && res_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_free) begin
      out_kind   <= res.kind;
      out_cmd    <= res.command;
      out_status <= res.status;
      out_rdata  <= res.read_data;
    end
  end

  assign m_axis_tuser = out_kind;
  assign m_axis_tdata = {6'd0, out_rdata, out_status, out_cmd};

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the serial boot packet loader: packet and read-back stimulus against a local predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbpl_pkg::*;

  localparam int ITEM_GOAL    = 1400;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 32;

  typedef logic [7:0] byte_q_t [$];

  typedef struct packed {
    logic       kind;
    logic [7:0] command;
    status_t    status;
    logic [7:0] read_data;
  } loader_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // rx_byte[7:0], read_addr[19:8]
  logic        s_axis_tuser = 1'b0; // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // command[7:0], status[9:8], read_data[17:10]
  logic        m_axis_tuser;        // kind

  serial_boot_packet_loader i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // Loader state as the predictor sees it
  status_t     p_status    = STAT_OK;
  logic [31:0] p_wr_ptr    = '0;
  logic [31:0] p_remaining = '0;
  phase_t      p_phase     = PH_SIZE;
  logic [7:0]  p_size      = '0;
  logic [7:0]  p_want_sum  = '0;
  logic [7:0]  p_got_sum   = '0;
  logic [7:0]  p_count     = '0;
  logic [7:0]  p_buf [BUF_LEN] = '{default: 8'h00};
  logic [7:0]  image [MEM_BYTES];

  loader_beat_t expected_loader_beats [$];

  int n_items     = 0;
  int n_packets   = 0;
  int n_reads     = 0;
  int n_clears    = 0;
  int n_checked   = 0;
  int n_errors    = 0;
  int burst_left  = 1;
  int mid_read_pct = 0;
  int idle_cycles = 0;
  bit [31:0] rx_cycle = '0;

  function automatic string beat_text(input loader_beat_t b);
    return $sformatf("kind=%0d cmd=%02h status=%0d data=%02h",
                     b.kind, b.command, b.status, b.read_data);
  endfunction

  function automatic void note_mismatch(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic int unsigned body_len();
    return (p_size >= 2) ? p_size - 2 : 0;
  endfunction

  // Big-endian word from the payload; bytes not received read as zero
  function automatic logic [31:0] body_be32(input int unsigned first);
    logic [31:0] v;
    int unsigned idx;
    v = '0;
    for (int k = 0; k < 4; k++) begin
      idx = first + k;
      v = {v[23:0], (idx < body_len() && idx < BUF_LEN) ? p_buf[idx] : 8'h00};
    end
    return v;
  endfunction

  function automatic logic [7:0] close_packet(input logic [7:0] term);
    logic [7:0]  cmd;
    logic [31:0] n;
    if (term != 8'h00 || p_want_sum != p_got_sum) p_status = STAT_INVALID;
    if (p_size < 3) begin
      p_status = STAT_INVALID;
      return 8'h00;
    end
    cmd = p_buf[0];
    n = p_size - 3;
    case (cmd)
      CMD_PING, CMD_RUN, CMD_STATUS: ;
      CMD_DOWNLOAD: begin
        p_wr_ptr    = body_be32(1);
        p_remaining = body_be32(5);
      end
      CMD_SEND: begin
        if (n > MAX_CHUNK) p_status = STAT_INVALID;
        else if ({1'b0, p_wr_ptr} + {1'b0, n} > 33'(MEM_BYTES)) p_status = STAT_ADDR;
        else if (p_remaining < n) p_status = STAT_INVALID;
        else begin
          for (int k = 1; k <= int'(n); k++) begin
            image[p_wr_ptr[MEM_AW-1:0]] = p_buf[k];
            p_wr_ptr++;
            p_remaining--;
          end
        end
      end
      CMD_RESET: begin
        p_wr_ptr    = '0;
        p_remaining = '0;
        foreach (image[i]) image[i] = 8'h00;
        n_clears++;
      end
      default: p_status = STAT_UNKNOWN;
    endcase
    return cmd;
  endfunction

  function automatic void predict_loader_beat(input logic op, input logic [7:0] b,
                                              input logic [11:0] a);
    loader_beat_t r;
    if (op == OP_READ) begin
      r.kind      = KIND_READ;
      r.command   = 8'h00;
      r.status    = p_status;
      r.read_data = image[a];
      expected_loader_beats.push_back(r);
      n_reads++;
      return;
    end
    case (p_phase)
      PH_SIZE: begin
        p_size    = b;
        p_got_sum = 8'h00;
        p_count   = 8'h00;
        foreach (p_buf[i]) p_buf[i] = 8'h00;
        p_phase   = PH_SUM;
      end
      PH_SUM: begin
        p_want_sum = b;
        p_phase    = (body_len() > 0) ? PH_DATA : PH_TERM;
      end
      PH_DATA: begin
        if (p_count < BUF_LEN) p_buf[p_count] = b;
        p_got_sum = p_got_sum + b;
        p_count++;
        if (p_count >= body_len()) p_phase = PH_TERM;
      end
      default: begin
        r.command   = close_packet(b);
        r.kind      = KIND_PACKET;
        r.status    = p_status;
        r.read_data = 8'h00;
        p_phase     = PH_SIZE;
        expected_loader_beats.push_back(r);
        n_packets++;
      end
    endcase
  endfunction

  // One input beat; the sender idles between bursts
  task automatic send_beat(input logic op, input logic [7:0] b, input logic [11:0] a);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'h0, a, b};
    do @(posedge clk); while (!s_axis_tready);
    predict_loader_beat(op, b, a);
    n_items++;
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 12);
    end
  endtask

  task automatic send_read(input logic [11:0] a);
    send_beat(OP_READ, 8'($urandom_range(0, 255)), a);
  endtask

  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < mid_read_pct) send_read(12'($urandom_range(0, MEM_BYTES - 1)));
    send_beat(OP_RX, b, 12'($urandom_range(0, 4095)));
  endtask

  task automatic send_frame(input logic [7:0] size, input logic [7:0] sum,
                            input byte_q_t body, input logic [7:0] term);
    send_byte(size);
    send_byte(sum);
    foreach (body[i]) send_byte(body[i]);
    send_byte(term);
  endtask

  task automatic send_packet(input byte_q_t body, input bit bad_sum, input bit bad_term);
    logic [7:0] sum;
    logic [7:0] term;
    sum = 8'h00;
    foreach (body[i]) sum = sum + body[i];
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    term = bad_term ? 8'($urandom_range(1, 255)) : 8'h00;
    send_frame(8'(body.size() + 2), sum, body, term);
  endtask

  function automatic byte_q_t download_body(input logic [31:0] addr, input logic [31:0] count);
    return {CMD_DOWNLOAD, addr[31:24], addr[23:16], addr[15:8], addr[7:0],
            count[31:24], count[23:16], count[15:8], count[7:0]};
  endfunction

  function automatic byte_q_t send_body(input int unsigned n);
    byte_q_t q;
    q = {CMD_SEND};
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  // Walks the parser back to the size byte after a broken stream
  task automatic resync_parser();
    while (p_phase != PH_SIZE) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic test_memory_clear();
    send_packet({CMD_RESET}, 1'b0, 1'b0);
  endtask

  task automatic test_control_cmds();
    byte_q_t body;
    send_packet({CMD_PING}, 1'b0, 1'b0);
    send_packet({CMD_RUN, 8'hFF, 8'h00}, 1'b0, 1'b0);
    send_packet({CMD_STATUS}, 1'b0, 1'b0);
    // longest packet: payload runs well past the buffer
    body = {CMD_PING, 8'hFF};
    repeat (251) body.push_back(8'($urandom_range(0, 255)));
    send_packet(body, 1'b0, 1'b0);
  endtask

  task automatic test_download_send();
    byte_q_t body;
    send_packet(download_body(MEM_BYTES - MAX_CHUNK, MAX_CHUNK), 1'b0, 1'b0);
    send_packet({CMD_SEND, 8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7F, 8'hFE},
                1'b0, 1'b0);
    send_packet(download_body(32'd0, 32'd3), 1'b0, 1'b0);
    send_packet({CMD_SEND, 8'hFF, 8'h00, 8'hA5}, 1'b0, 1'b0);
    send_packet({CMD_SEND}, 1'b0, 1'b0);
    // nothing left to receive
    send_packet({CMD_SEND, 8'h11}, 1'b0, 1'b0);
    send_packet(download_body(32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, 1'b0);
    send_packet({CMD_SEND, 8'h22}, 1'b0, 1'b0);
    send_packet(send_body(MAX_CHUNK + 1), 1'b0, 1'b0);
    // truncated download: missing bytes read as zero
    send_packet({CMD_DOWNLOAD, 8'h00, 8'h00}, 1'b0, 1'b0);
    body = download_body(32'd16, 32'd5);
    repeat (4) body.push_back(8'($urandom_range(0, 255)));
    send_packet(body, 1'b0, 1'b0);
    send_packet(send_body(4), 1'b0, 1'b0);
  endtask

  task automatic test_framing_errors();
    send_packet({CMD_PING}, 1'b1, 1'b0);
    send_frame(8'd3, CMD_PING, {CMD_PING}, 8'hFF);
    send_packet({CMD_STATUS, 8'h01}, 1'b1, 1'b1);
  endtask

  task automatic test_unknown_cmd();
    send_packet({8'h00}, 1'b0, 1'b0);
    send_packet({8'hFF, 8'h12}, 1'b0, 1'b0);
    send_packet({8'h1F}, 1'b0, 1'b0);
    send_packet({8'h26}, 1'b0, 1'b0);
  endtask

  task automatic test_short_packets();
    byte_q_t none;
    send_frame(8'd0, 8'h00, none, 8'h00);
    send_frame(8'd1, 8'hFF, none, 8'hFF);
    send_frame(8'd2, 8'h00, none, 8'h00);
  endtask

  task automatic test_reads();
    send_read(12'd0);
    send_read(12'hFFF);
    send_read(12'(MEM_BYTES - MAX_CHUNK));
    send_read(12'd17);
    mid_read_pct = 50;
    send_packet({CMD_RUN, 8'h33, 8'hCC}, 1'b0, 1'b0);
    mid_read_pct = 0;
  endtask

  task automatic random_packet();
    byte_q_t     body;
    byte_q_t     none;
    int unsigned pick;
    int unsigned n;
    logic [31:0] addr;
    logic [31:0] count;
    logic [7:0]  cmd;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      case ($urandom_range(0, 2))
        0:       body = {CMD_PING};
        1:       body = {CMD_RUN};
        default: body = {CMD_STATUS};
      endcase
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 252) : $urandom_range(0, 3);
      repeat (n) body.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 30) begin
      case ($urandom_range(0, 9))
        7, 8:    addr = $urandom_range(MEM_BYTES - 2 * MAX_CHUNK, MEM_BYTES - 1);
        9:       addr = $urandom;
        default: addr = $urandom_range(0, MEM_BYTES - 1);
      endcase
      count = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 48);
      body = download_body(addr, count);
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 8);
        while (body.size() > n) void'(body.pop_back());
      end
    end else if (pick < 80) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_CHUNK + 1, MAX_CHUNK + 6)
                                      : $urandom_range(0, MAX_CHUNK);
      body = send_body(n);
    end else if (pick < 82) begin
      body = {CMD_RESET};
    end else if (pick < 92) begin
      cmd = 8'($urandom_range(0, 255));
      if (cmd >= CMD_PING && cmd <= CMD_RESET) cmd = cmd ^ 8'h80;
      body = {cmd};
      repeat ($urandom_range(0, 4)) body.push_back(8'($urandom_range(0, 255)));
    end else begin
      send_frame(8'($urandom_range(0, 2)), 8'($urandom_range(0, 255)), none,
                 ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
      return;
    end
    send_packet(body, $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0);
  endtask

  task automatic test_random();
    int unsigned pick;
    int unsigned len;
    mid_read_pct = 8;
    while (n_items < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_read(12'($urandom_range(0, MEM_BYTES - 1)));
      end else if (pick < 16) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
        resync_parser();
      end else if (pick < 20) begin
        // packet cut short, then the stream is realigned
        len = $urandom_range(3, 20);
        send_byte(8'(len));
        send_byte(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, len - 3)) send_byte(8'($urandom_range(0, 255)));
        resync_parser();
        resync_parser();
      end else begin
        random_packet();
      end
    end
    mid_read_pct = 0;
  endtask

  // Receiver: cycles through always-ready, random, periodic and long-stall phases
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[9:8])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= ($urandom_range(0, 2) != 0);
      2'd2:    m_axis_tready <= ((rx_cycle % 5) < 2);
      default: m_axis_tready <= (rx_cycle[4:0] >= 5'd12);
    endcase
  end

  always @(posedge clk) begin : result_check
    loader_beat_t got;
    loader_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind      = m_axis_tuser;
      got.command   = m_axis_tdata[7:0];
      got.status    = status_t'(m_axis_tdata[9:8]);
      got.read_data = m_axis_tdata[17:10];
      if (expected_loader_beats.size() == 0) begin
        note_mismatch($sformatf("result with none due: %s", beat_text(got)));
      end else begin
        want = expected_loader_beats.pop_front();
        n_checked++;
        if (got !== want)
          note_mismatch($sformatf("expected %s, got %s", beat_text(want), beat_text(got)));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_loader_beats.size());
        $display("serial_boot_packet_loader verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_memory_clear();
    test_control_cmds();
    test_download_send();
    test_framing_errors();
    test_unknown_cmd();
    test_short_packets();
    test_reads();
    test_random();
    s_axis_tvalid <= 1'b0;
    while (expected_loader_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d input beats: %0d packets closed, %0d memory reads, %0d memory clears.",
             n_items, n_packets, n_reads, n_clears);
    $display("Checked %0d result beats, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("serial_boot_packet_loader verification clean");
    end else begin
      $display("serial_boot_packet_loader verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
design/sbpl_pkg.sv
design/sbpl_ram.sv
design/sbpl_parser.sv
design/sbpl_engine.sv
design/serial_boot_packet_loader.sv
dv/tb.sv
